// ===== sv/dbga_pkg.sv =====
// Package for the distinct-bin greedy allocator: payload structs, sizes,
// opcodes and the control state type. No dependencies.
`default_nettype none
package dbga_pkg;
  localparam int NUM_BINS = 64;
  localparam int IDX_W    = 6;
  localparam int CAP_W    = 8;
  localparam int CNT_W    = 7;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_REQUEST = 1'b1
  } opcode_t;

  typedef struct packed {
    logic             opcode;
    logic [IDX_W-1:0] bin_index;
    logic [CAP_W-1:0] capacity;
    logic [CNT_W-1:0] group_size;
  } in_word_t;

  typedef struct packed {
    logic                granted;
    logic [NUM_BINS-1:0] bin_mask;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COUNT,
    ST_PICK,
    ST_DEC,
    ST_DONE
  } state_t;
endpackage
`default_nettype wire

// ===== sv/distinct_bin_greedy_allocator.sv =====
// Top level of the distinct-bin greedy allocator: capacity memory, scan
// sequencer and result register. Depends on dbga_pkg.
`default_nettype none
// One item at a time. busy is high from the accepting edge until the result
// strobe. A load writes its bin at the accepting edge, then passes through
// ST_DONE to the strobe. A request, with n = effective bins in use and k =
// group_size, sweeps the capacity memory once over the n bins to count
// nonzero bins, then once per granted unit to find the maximum (k sweeps),
// then once to decrement chosen bins, and passes through ST_DONE to the
// result strobe. Requests that fail or are blocked end after the count sweep
// or at once. The result strobe cannot be stalled. Capacities reset to zero
// through a clearing pass over all 64 bins after reset, during which busy is
// high; configuration writes are taken at any time.
module distinct_bin_greedy_allocator
  import dbga_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire in_word_t  in_word,
  output logic           out_strobe,
  output out_word_t      out_word,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic [CNT_W-1:0] cfg_data
);
  logic [CAP_W-1:0] mem [NUM_BINS];
  logic [CAP_W-1:0] rd_data_r;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] bins_r;
  logic             failed_r, failed_nxt;
  logic             clear_r;
  logic [CNT_W-1:0] clr_cnt_r;
  in_word_t         item_r;
  logic [CNT_W-1:0] nb_r;
  logic [CNT_W-1:0] scan_r, scan_nxt;     // address issued, one ahead of data
  logic [CNT_W-1:0] left_r, left_nxt;     // picks still to make
  logic [CNT_W-1:0] avail_r, avail_nxt;
  logic [NUM_BINS-1:0] mask_r, mask_nxt;
  logic [CAP_W-1:0] best_cap_r, best_cap_nxt;
  logic [IDX_W-1:0] best_idx_r, best_idx_nxt;
  logic             best_ok_r, best_ok_nxt;
  logic             strobe_nxt, granted_nxt;

  logic             we;
  logic [IDX_W-1:0] waddr, raddr;
  logic [CAP_W-1:0] wdata;
  logic [CNT_W-1:0] nb_eff;
  logic             data_ok;               // rd_data_r belongs to bin scan_r-1
  logic [IDX_W-1:0] data_idx;
  logic [CNT_W-1:0] data_idx_w;

  assign cfg_ready = 1'b1;
  assign busy      = clear_r || (state_r != ST_IDLE);
  assign nb_eff    = (bins_r > CNT_W'(NUM_BINS)) ? CNT_W'(NUM_BINS) : bins_r;
  assign data_idx_w = scan_r - CNT_W'(1);
  assign data_idx  = data_idx_w[IDX_W-1:0];
  assign data_ok   = (scan_r != '0) && (data_idx_w < nb_r);
  assign raddr     = scan_r[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[raddr];
  end

  always_comb begin
    state_nxt    = state_r;
    failed_nxt   = failed_r;
    scan_nxt     = scan_r;
    left_nxt     = left_r;
    avail_nxt    = avail_r;
    mask_nxt     = mask_r;
    best_cap_nxt = best_cap_r;
    best_idx_nxt = best_idx_r;
    best_ok_nxt  = best_ok_r;
    strobe_nxt   = 1'b0;
    granted_nxt  = 1'b0;
    we           = 1'b0;
    waddr        = data_idx;
    wdata        = rd_data_r - CAP_W'(1);
    if (clear_r) begin
      we    = 1'b1;
      waddr = clr_cnt_r[IDX_W-1:0];
      wdata = '0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (start && !busy) begin
          scan_nxt = '0;
          if (in_word.opcode == OP_LOAD) begin
            we         = 1'b1;
            waddr      = in_word.bin_index;
            wdata      = in_word.capacity;
            failed_nxt = 1'b0;
            state_nxt  = ST_DONE;
          end else begin
            state_nxt  = ST_COUNT;
            avail_nxt  = '0;
            mask_nxt   = '0;
          end
        end
      end
      ST_COUNT: begin
        scan_nxt = scan_r + CNT_W'(1);
        if (data_ok && rd_data_r != '0) begin
          avail_nxt = avail_r + CNT_W'(1);
        end
        if (scan_r == nb_r) begin
          scan_nxt = '0;
          if (failed_r) begin
            state_nxt = ST_DONE;
          end else if (item_r.group_size > nb_r || item_r.group_size > avail_nxt) begin
            failed_nxt = 1'b1;
            state_nxt  = ST_DONE;
          end else if (item_r.group_size == '0) begin
            state_nxt = ST_DONE;
          end else begin
            left_nxt    = item_r.group_size;
            best_cap_nxt = '0;
            best_ok_nxt  = 1'b0;
            state_nxt   = ST_PICK;
          end
        end
      end
      ST_PICK: begin
        scan_nxt = scan_r + CNT_W'(1);
        if (data_ok && !mask_r[data_idx] && rd_data_r > best_cap_r) begin
          best_cap_nxt = rd_data_r;
          best_idx_nxt = data_idx;
          best_ok_nxt  = 1'b1;
        end
        if (scan_r == nb_r) begin
          scan_nxt = '0;
          if (best_ok_nxt) begin
            mask_nxt[best_idx_nxt] = 1'b1;
          end
          best_cap_nxt = '0;
          best_ok_nxt  = 1'b0;
          left_nxt     = left_r - CNT_W'(1);
          if (left_r == CNT_W'(1)) begin
            state_nxt = ST_DEC;
          end
        end
      end
      ST_DEC: begin
        scan_nxt = scan_r + CNT_W'(1);
        if (data_ok && mask_r[data_idx]) begin
          we = 1'b1;
        end
        if (scan_r == nb_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        strobe_nxt  = 1'b1;
        granted_nxt = (item_r.opcode == OP_LOAD) ? 1'b1 :
                      (!failed_r && left_r == '0);
        state_nxt   = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      failed_r   <= 1'b0;
      bins_r     <= CNT_W'(NUM_BINS);
      clear_r    <= 1'b1;
      clr_cnt_r  <= '0;
      out_strobe <= 1'b0;
      left_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      failed_r   <= failed_nxt;
      out_strobe <= strobe_nxt;
      left_r     <= left_nxt;
      if (cfg_valid && cfg_ready) begin
        bins_r <= cfg_data;
      end
      if (clear_r) begin
        clr_cnt_r <= clr_cnt_r + CNT_W'(1);
        if (clr_cnt_r == CNT_W'(NUM_BINS - 1)) begin
          clear_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start && !busy) begin
      item_r <= in_word;
      nb_r   <= nb_eff;
      if (in_word.opcode == OP_REQUEST && failed_r) begin
        nb_r <= '0;
      end
    end
    scan_r     <= scan_nxt;
    avail_r    <= avail_nxt;
    mask_r     <= mask_nxt;
    best_cap_r <= best_cap_nxt;
    best_idx_r <= best_idx_nxt;
    best_ok_r  <= best_ok_nxt;
    out_word.granted  <= granted_nxt;
    out_word.bin_mask <= (granted_nxt && item_r.opcode == OP_REQUEST) ? mask_r : '0;
  end

  // Loads cannot address beyond the 64 memory bins: the index is 6 bits.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r) == ST_DONE)
    else $error("strobe without finished item");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_word.granted |-> out_word.bin_mask == '0)
    else $error("mask on failure");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("busy at result");
endmodule
`default_nettype wire
